### rtl/core/cbp_pkg.sv
package cbp_pkg;

    // Largest cursor side in pixels; sizes above it are clamped to it
    localparam logic [6:0] DIM_MAX = 7'd64;

    // Register file of the configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BITMAP_WIDTH  = 1'b0,
        REG_BITMAP_HEIGHT = 1'b1
    } t_cfg_reg;

    // Pixel and counter widths
    localparam int CH_W  = 8;
    localparam int CNT_W = 6;

    localparam logic [CFG_DAT_W-1:0] DIM_RESET = 7'd16;

    // Luminance weights, sum is scaled by 256
    localparam logic [7:0] LUM_R = 8'd77;
    localparam logic [7:0] LUM_G = 8'd151;
    localparam logic [7:0] LUM_B = 8'd28;
    localparam logic [7:0] ALPHA_TH = 8'd128;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic [7:0] mask_byte;
        logic [7:0] source_byte;
        logic [2:0] byte_column;
        logic [5:0] row_number;
        logic       last_byte;
    } t_result;

    // Clamp a written size to the usable range
    function automatic logic [CFG_DAT_W-1:0] eff_dim(input logic [CFG_DAT_W-1:0] v);
        logic [CFG_DAT_W-1:0] r;
        if (v == '0) begin
            r = 7'd1;
        end else if (v > DIM_MAX) begin
            r = DIM_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### rtl/core/cbp_channels.sv
interface cbp_pixel_if import cbp_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] alpha;

    modport source (output valid, blue, green, red, alpha, input ready);
    modport sink   (input valid, blue, green, red, alpha, output ready);
endinterface

interface cbp_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] mask_byte;
    logic [7:0] source_byte;
    logic [2:0] byte_column;
    logic [5:0] row_number;
    logic       last_byte;

    modport source (output valid, mask_byte, source_byte, byte_column, row_number,
                    last_byte, input ready);
    modport sink   (input valid, mask_byte, source_byte, byte_column, row_number,
                    last_byte, output ready);
endinterface

interface cbp_cfg_if import cbp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/cursor_bitmap_packer_top.sv
// Channel    Dir  Payload                                              Handshake
// i_pixel    in   blue, green, red, alpha (8b each)                    valid/ready
// o_result   out  mask_byte, source_byte, byte_column, row_number,     valid/ready
//                 last_byte
// i_cfg      in   index (0 width, 1 height), data (7b)                 valid/ready
//
// One pixel per cycle sustained while the result side keeps up; a pixel is held in the input
// register, and the byte it completes is then loaded into the result register.
// Reset is synchronous active low: sizes return to 16x16, counters and planes clear.
// The input register stalls only when a byte must be produced and the result register
// still holds an untaken byte; configuration writes are always taken.
module cursor_bitmap_packer_top
    import cbp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    cbp_pixel_if.sink     i_pixel,
    cbp_result_if.source  o_result,
    cbp_cfg_if.sink       i_cfg
);

    logic [CFG_DAT_W-1:0] r_width;
    logic [CFG_DAT_W-1:0] r_height;
    logic [CNT_W-1:0]     r_col, n_col;
    logic [CNT_W-1:0]     r_row, n_row;
    logic [7:0]           r_mask, n_mask;
    logic [7:0]           r_src, n_src;
    logic                 r_px_valid;
    t_pixel               r_px;
    logic                 r_out_valid;
    t_result              r_out;

    logic        cfg_wr;
    logic        row_end;
    logic        last_row;
    logic        emit;
    logic        out_free;
    logic        px_adv;
    logic [15:0] lum_sum;
    logic        mask_bit;
    logic        src_bit;
    logic [7:0]  bit_sel;

    assign i_cfg.ready   = 1'b1;
    assign cfg_wr        = i_cfg.valid && i_cfg.ready;

    // Pixel classification and byte packing
    always_comb begin
        lum_sum  = 16'(r_px.red) * 16'(LUM_R) + 16'(r_px.green) * 16'(LUM_G)
                 + 16'(r_px.blue) * 16'(LUM_B);
        mask_bit = (r_px.alpha >= ALPHA_TH);
        src_bit  = mask_bit && lum_sum[15];
        bit_sel  = 8'd1 << r_col[2:0];
        n_mask   = r_mask | (mask_bit ? bit_sel : 8'd0);
        n_src    = r_src  | (src_bit  ? bit_sel : 8'd0);

        row_end  = ({1'b0, r_col} + 7'd1) >= r_width;
        last_row = ({1'b0, r_row} + 7'd1) >= r_height;
        emit     = row_end || (r_col[2:0] == 3'd7);

        n_col    = row_end ? '0 : r_col + 1'b1;
        n_row    = row_end ? (last_row ? '0 : r_row + 1'b1) : r_row;
    end

    // Advance when no byte is due or the result register can take it
    assign out_free      = !r_out_valid || o_result.ready;
    assign px_adv        = r_px_valid && (!emit || out_free);
    assign i_pixel.ready = !r_px_valid || px_adv;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
        end else if (cfg_wr) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_BITMAP_WIDTH:  r_width  <= eff_dim(i_cfg.data);
                REG_BITMAP_HEIGHT: r_height <= eff_dim(i_cfg.data);
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px_valid <= 1'b0;
        end else if (i_pixel.ready) begin
            r_px_valid <= i_pixel.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pixel.ready) begin
            r_px.blue  <= i_pixel.blue;
            r_px.green <= i_pixel.green;
            r_px.red   <= i_pixel.red;
            r_px.alpha <= i_pixel.alpha;
        end
    end

    // Position counters and plane accumulators; a size write restarts the bitmap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_col  <= '0;
            r_row  <= '0;
            r_mask <= '0;
            r_src  <= '0;
        end else if (px_adv) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_mask <= emit ? 8'd0 : n_mask;
            r_src  <= emit ? 8'd0 : n_src;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (px_adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (px_adv && emit) begin
            r_out.mask_byte   <= n_mask;
            r_out.source_byte <= n_src;
            r_out.byte_column <= r_col[5:3];
            r_out.row_number  <= r_row;
            r_out.last_byte   <= row_end && last_row;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.mask_byte   = r_out.mask_byte;
    assign o_result.source_byte = r_out.source_byte;
    assign o_result.byte_column = r_out.byte_column;
    assign o_result.row_number  = r_out.row_number;
    assign o_result.last_byte   = r_out.last_byte;

`ifndef NO_ASSERTIONS
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col} < r_width)
        else $error("column counter beyond bitmap width");

    a_row_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_row} < r_height)
        else $error("row counter beyond bitmap height");

    a_mask_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask >> r_col[2:0]) == 8'd0)
        else $error("mask bits set at or past the current column");

    a_src_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_src & ~r_mask) == 8'd0)
        else $error("source bit set without mask bit");

    a_dim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_width != '0 && r_width <= DIM_MAX
        && r_height != '0 && r_height <= DIM_MAX)
        else $error("stored bitmap size out of range");
`endif

endmodule

### tb/cbp_packer_checker.sv
module cbp_packer_checker
    import cbp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    cbp_pixel_if   i_pixel,
    cbp_result_if  i_result,
    cbp_cfg_if     i_cfg,
    output int     o_errors,
    output int     o_pending
);

    // Shadow copy of the size registers and the packing state
    logic [CFG_DAT_W-1:0] width_reg;
    logic [CFG_DAT_W-1:0] height_reg;
    logic [CNT_W-1:0]     col_pos;
    logic [CNT_W-1:0]     row_pos;
    logic [7:0]           mask_acc;
    logic [7:0]           src_acc;

    // Plane bytes predicted but not yet seen on the result channel
    t_result bytes_due[$];
    int      errors = 0;
    int      pending_cnt = 0;

    assign o_errors  = errors;
    assign o_pending = pending_cnt;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] plane byte error: %s", $time, msg);
    endtask

    // Map a written size onto the 1..DIM_MAX range actually used
    function automatic int unsigned side_in_use(input logic [CFG_DAT_W-1:0] v);
        int unsigned n;
        n = (v == '0) ? 1 : int'(v);
        return (n > int'(DIM_MAX)) ? int'(DIM_MAX) : n;
    endfunction

    // Fold one pixel into the planes; return 1 when a byte pair is due
    function automatic bit pack_pixel(input t_pixel px, output t_result bytes);
        int unsigned cols;
        int unsigned rows;
        int unsigned luma;
        logic [7:0]  bit_sel;
        bit          row_done;
        bit          emit;
        cols    = side_in_use(width_reg);
        rows    = side_in_use(height_reg);
        bit_sel = 8'd1 << col_pos[2:0];
        bytes   = '0;

        // Opaque pixels draw; bright opaque pixels are foreground white
        if (px.alpha >= ALPHA_TH) begin
            luma = (int'(LUM_R) * int'(px.red) + int'(LUM_G) * int'(px.green)
                    + int'(LUM_B) * int'(px.blue)) >> 8;
            mask_acc = mask_acc | bit_sel;
            if (luma >= 128) begin
                src_acc = src_acc | bit_sel;
            end
        end

        row_done = (int'(col_pos) + 1 >= cols);
        emit     = row_done || (col_pos[2:0] == 3'd7);
        if (emit) begin
            bytes.mask_byte   = mask_acc;
            bytes.source_byte = src_acc;
            bytes.byte_column = col_pos[5:3];
            bytes.row_number  = row_pos;
            bytes.last_byte   = row_done && (int'(row_pos) + 1 >= rows);
            mask_acc = '0;
            src_acc  = '0;
        end

        // Advance the raster position, wrapping after the last row
        if (row_done) begin
            col_pos = '0;
            row_pos = (int'(row_pos) + 1 >= rows) ? '0 : row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
        return emit;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        t_result due;
        t_pixel  px;
        if (!i_rst_n) begin
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            col_pos    = '0;
            row_pos    = '0;
            mask_acc   = '0;
            src_acc    = '0;
            bytes_due.delete();
        end else begin
            // Compare a result transfer with the oldest predicted byte pair
            if (i_result.valid && i_result.ready) begin
                got.mask_byte   = i_result.mask_byte;
                got.source_byte = i_result.source_byte;
                got.byte_column = i_result.byte_column;
                got.row_number  = i_result.row_number;
                got.last_byte   = i_result.last_byte;
                if (bytes_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte pair mask %0h source %0h",
                                              got.mask_byte, got.source_byte));
                end else begin
                    want = bytes_due.pop_front();
                    if (got.mask_byte !== want.mask_byte)
                        report_mismatch($sformatf("mask_byte got %0h want %0h",
                                                  got.mask_byte, want.mask_byte));
                    if (got.source_byte !== want.source_byte)
                        report_mismatch($sformatf("source_byte got %0h want %0h",
                                                  got.source_byte, want.source_byte));
                    if (got.byte_column !== want.byte_column)
                        report_mismatch($sformatf("byte_column got %0d want %0d",
                                                  got.byte_column, want.byte_column));
                    if (got.row_number !== want.row_number)
                        report_mismatch($sformatf("row_number got %0d want %0d",
                                                  got.row_number, want.row_number));
                    if (got.last_byte !== want.last_byte)
                        report_mismatch($sformatf("last_byte got %0b want %0b",
                                                  got.last_byte, want.last_byte));
                end
            end

            // A size write also restarts the bitmap
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_reg'(i_cfg.index))
                    REG_BITMAP_WIDTH: begin
                        width_reg = i_cfg.data;
                    end
                    REG_BITMAP_HEIGHT: begin
                        height_reg = i_cfg.data;
                    end
                    default: begin
                    end
                endcase
                col_pos  = '0;
                row_pos  = '0;
                mask_acc = '0;
                src_acc  = '0;
            end

            if (i_pixel.valid && i_pixel.ready) begin
                px.blue  = i_pixel.blue;
                px.green = i_pixel.green;
                px.red   = i_pixel.red;
                px.alpha = i_pixel.alpha;
                if (pack_pixel(px, due)) begin
                    bytes_due.push_back(due);
                end
            end
        end
        pending_cnt <= bytes_due.size();
    end

endmodule

### tb/tb.sv
module tb;
    import cbp_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PIXEL_TARGET = 1950;
    localparam int SETTLE       = 4;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   bytes_pending;
    int   burst_left = 0;
    int   pixels_sent = 0;
    bit   hold_req = 1'b0;

    cbp_pixel_if  pixel_ch();
    cbp_result_if result_ch();
    cbp_cfg_if    cfg_ch();

    cursor_bitmap_packer_top u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_pixel  (pixel_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    cbp_packer_checker u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_pixel   (pixel_ch),
        .i_result  (result_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (fail_count),
        .o_pending (bytes_pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic t_pixel make_pixel(input int b, input int g, input int r, input int a);
        t_pixel p;
        p.blue  = b[7:0];
        p.green = g[7:0];
        p.red   = r[7:0];
        p.alpha = a[7:0];
        return p;
    endfunction

    // Random pixel, biased toward the alpha and luminance thresholds
    function automatic t_pixel random_pixel();
        t_pixel p;
        int     gray;
        p.blue  = 8'($urandom_range(0, 255));
        p.green = 8'($urandom_range(0, 255));
        p.red   = 8'($urandom_range(0, 255));
        p.alpha = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0: begin
                gray    = $urandom_range(124, 132);
                p.blue  = gray[7:0];
                p.green = gray[7:0];
                p.red   = gray[7:0];
            end
            1: begin
                p.alpha = 8'($urandom_range(120, 135));
            end
            2: begin
                p.alpha = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: begin
            end
        endcase
        return p;
    endfunction

    // Offer one pixel, inserting a random gap between bursts
    task automatic put_pixel(input t_pixel p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                pixel_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 64);
        end
        burst_left--;
        pixel_ch.valid <= 1'b1;
        pixel_ch.blue  <= p.blue;
        pixel_ch.green <= p.green;
        pixel_ch.red   <= p.red;
        pixel_ch.alpha <= p.alpha;
        do @(posedge clk); while (!pixel_ch.ready);
        pixels_sent++;
    endtask

    // Hold the sender until every predicted byte has arrived, then settle
    task automatic drain();
        pixel_ch.valid <= 1'b0;
        do @(posedge clk); while (bytes_pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write width then height back to back; both restart the bitmap
    task automatic set_size(input logic [CFG_DAT_W-1:0] w, input logic [CFG_DAT_W-1:0] h);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_BITMAP_WIDTH;
        cfg_ch.data  <= w;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= REG_BITMAP_HEIGHT;
        cfg_ch.data  <= h;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic int side_of(input logic [CFG_DAT_W-1:0] v);
        if (v == '0) return 1;
        return (int'(v) > int'(DIM_MAX)) ? int'(DIM_MAX) : int'(v);
    endfunction

    // Receiver: random ready patterns, plus a long hold-off on request
    initial begin : receiver
        int run;
        int mode;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                run  = $urandom_range(1, 40);
                repeat (run) begin
                    case (mode)
                        0: result_ch.ready <= 1'b1;
                        1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                        2: result_ch.ready <= 1'($urandom_range(0, 1));
                        default: result_ch.ready <= ($urandom_range(0, 4) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // End the run when no channel has moved a transfer for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        t_pixel               first_row[16];
        logic [CFG_DAT_W-1:0] w;
        logic [CFG_DAT_W-1:0] h;
        int                   area;
        int                   count;

        pixel_ch.valid <= 1'b0;
        pixel_ch.blue  <= '0;
        pixel_ch.green <= '0;
        pixel_ch.red   <= '0;
        pixel_ch.alpha <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= REG_BITMAP_WIDTH;
        cfg_ch.data    <= '0;
        rst_n          <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One row at the reset size: thresholds, primaries, extremes
        first_row[0]  = make_pixel(0, 0, 0, 0);
        first_row[1]  = make_pixel(255, 255, 255, 255);
        first_row[2]  = make_pixel(255, 255, 255, 127);
        first_row[3]  = make_pixel(255, 255, 255, 128);
        first_row[4]  = make_pixel(128, 128, 128, 255);
        first_row[5]  = make_pixel(127, 127, 127, 255);
        first_row[6]  = make_pixel(0, 0, 255, 255);
        first_row[7]  = make_pixel(0, 255, 0, 255);
        first_row[8]  = make_pixel(255, 0, 0, 255);
        first_row[9]  = make_pixel(0, 0, 0, 255);
        first_row[10] = make_pixel(255, 255, 255, 0);
        first_row[11] = make_pixel(128, 128, 128, 128);
        first_row[12] = make_pixel(127, 127, 127, 128);
        first_row[13] = make_pixel(255, 255, 0, 200);
        first_row[14] = make_pixel(170, 85, 170, 85);
        first_row[15] = make_pixel(85, 170, 85, 170);
        foreach (first_row[i]) put_pixel(first_row[i]);

        // Size zero runs as one pixel: every pixel is a whole bitmap
        drain();
        set_size('0, '0);
        put_pixel(make_pixel(128, 128, 128, 255));
        put_pixel(make_pixel(0, 0, 0, 128));

        // Short row padded to a whole byte
        drain();
        set_size(7'd3, 7'd1);
        put_pixel(make_pixel(255, 255, 255, 255));
        put_pixel(make_pixel(0, 0, 0, 0));
        put_pixel(make_pixel(255, 255, 255, 255));

        // Tallest bitmap one pixel wide, then the widest rows (above the clamp)
        drain();
        set_size(7'd1, 7'd64);
        repeat (64) put_pixel(random_pixel());
        drain();
        set_size(7'd127, 7'd127);
        repeat (160) put_pixel(random_pixel());

        // Stall the result side while pixels keep coming so the input backs up
        drain();
        set_size(7'd1, 7'd5);
        hold_req = 1'b1;
        repeat (80) put_pixel(random_pixel());

        // Random sizes, mostly whole bitmaps, some cut short by the next write
        while (pixels_sent < PIXEL_TARGET) begin
            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 4))
                        0: w = 7'd0;
                        1: w = 7'd64;
                        2: w = 7'd65;
                        3: w = 7'd100;
                        default: w = 7'd127;
                    endcase
                end
                1, 2: w = 7'($urandom_range(9, 40));
                default: w = 7'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 7))
                0: begin
                    case ($urandom_range(0, 3))
                        0: h = 7'd0;
                        1: h = 7'd64;
                        2: h = 7'd127;
                        default: h = 7'd1;
                    endcase
                end
                default: h = 7'($urandom_range(1, 6));
            endcase
            area  = side_of(w) * side_of(h);
            count = (area <= 200) ? area * $urandom_range(1, 2) : $urandom_range(64, 240);
            if ($urandom_range(0, 3) == 0) begin
                count += $urandom_range(1, side_of(w));
            end
            // Keep the total close to the target
            if (count > PIXEL_TARGET - pixels_sent) begin
                count = PIXEL_TARGET - pixels_sent;
            end
            drain();
            set_size(w, h);
            repeat (count) put_pixel(random_pixel());
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
